// File: sv/online_mean_variance_stats_core_defines.svh
// Assertion shorthands for the statistics core
`ifndef ONLINE_MEAN_VARIANCE_STATS_CORE_DEFINES_SVH
`define ONLINE_MEAN_VARIANCE_STATS_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock out of reset
`define OMVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock out of reset
`define OMVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/omvs_pkg.sv
package omvs_pkg;

  localparam int unsigned CNT_W   = 25;
  localparam int unsigned MEAN_W  = 50;
  localparam int unsigned MAG_W   = 49;
  localparam int unsigned DIV_NW  = 64;
  localparam int unsigned DIV_DW  = 29;
  localparam logic [16:0] Z95_Q16 = 17'd128451;
  localparam logic [6:0]  CONV_FACTOR = 7'd100;
  localparam logic [24:0] ITER_RESET = 25'd10000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_STEP_GO, ST_STEP_WAIT, ST_MEAN, ST_MUL_GO, ST_MUL_WAIT, ST_ACC,
    ST_VAR_GO, ST_VAR_WAIT, ST_SIG_GO, ST_SIG_WAIT, ST_RN_GO, ST_RN_WAIT,
    ST_HW_MUL, ST_HW_GO, ST_HW_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mean_upd;
    logic mul_go;
    logic acc;
    logic div_var;
    logic sig_zero;
    logic sig_sat;
    logic sqrt_sig;
    logic sig_take;
    logic sqrt_rn;
    logic rn_take;
    logic hw_mul;
    logic div_hw;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic mul_done;
    logic run_end;
    logic multi;
    logic var_big;
  } sts_t;

endpackage

// File: sv/omvs_div.sv
module omvs_div import omvs_pkg::*; #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 29
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int unsigned STEPS = NW / 2;
  localparam int unsigned CW = $clog2(STEPS + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [DW:0]   t1, t2;
  logic          ge1, ge2;
  logic [DW-1:0] r1, r2;
  logic [NW-1:0] q1, q2;

  // Two restoring steps per clock
  always_comb begin
    t1  = {rem_r, q_r[NW-1]};
    ge1 = t1 >= {1'b0, d_r};
    r1  = ge1 ? DW'(t1 - {1'b0, d_r}) : t1[DW-1:0];
    q1  = {q_r[NW-2:0], ge1};
    t2  = {r1, q1[NW-1]};
    ge2 = t2 >= {1'b0, d_r};
    r2  = ge2 ? DW'(t2 - {1'b0, d_r}) : t2[DW-1:0];
    q2  = {q1[NW-2:0], ge2};
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the working words
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (run_r) begin
      q_r   <= q2;
      rem_r <= r2;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// File: sv/omvs_sqrt.sv
module omvs_sqrt import omvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x_r, r_r, bit_r, trial;
  logic [5:0]  cnt_r;
  logic        run_r, done_r, fits;

  always_comb begin
    trial = r_r + bit_r;
    fits  = x_r >= trial;
  end

  // Sequence the 32 digit steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'd32;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One root digit per clock
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (run_r) begin
      if (fits) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];
endmodule

// File: sv/omvs_dp.sv
module omvs_dp import omvs_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [CNT_W-1:0] limit,
  input  logic [31:0]      sample,
  output logic             out_valid,
  output logic [31:0]      out_run_mean,
  output logic [31:0]      out_run_stddev,
  output logic [31:0]      out_run_minimum,
  output logic [31:0]      out_run_maximum,
  output logic [31:0]      out_half_width,
  output logic             out_converged,
  output logic [31:0]      out_runs_total,
  output logic [31:0]      out_runs_converged,
  output logic             out_m2_saturated
);
  logic signed [31:0]       y_r, min_r, max_r;
  logic [CNT_W-1:0]         cnt_r, n_r;
  logic signed [MEAN_W-1:0] mean_r, yq, delta, delta2;
  logic [MAG_W-1:0]         dmag_r, d2mag;
  logic                     dneg_r, sat_r;
  logic [63:0]              sq_r;
  logic [51:0]              mulb_r;
  logic [100:0]             prod_r;
  logic [1:0]               mcnt_r;
  logic                     mrun_r, mdone_r;
  logic [44:0]              term;
  logic [64:0]              sum;
  logic [31:0]              sigma_r, sq_root, tot_r, conv_r;
  logic [DIV_DW-1:0]        rootn_r;
  logic [48:0]              hwp_r;
  logic                     div_go, div_done, sqrt_go, sqrt_done;
  logic [DIV_NW-1:0]        div_a, div_q;
  logic [DIV_DW-1:0]        div_b;
  logic [63:0]              sqrt_x;
  logic [MAG_W-1:0]         mean_mag;
  logic [32:0]              mmag;
  logic [31:0]              mean16;
  logic [38:0]              sig100;
  logic                     conv;

  // Sample arithmetic
  always_comb begin
    yq       = {{2{y_r[31]}}, y_r, 16'b0};
    delta    = yq - mean_r;
    delta2   = yq - mean_r;
    d2mag    = delta2[MEAN_W-1] ? MAG_W'(-delta2) : delta2[MAG_W-1:0];
    term     = prod_r[100:56];
    sum      = {1'b0, sq_r} + 65'(term);
    mean_mag = mean_r[MEAN_W-1] ? MAG_W'(-mean_r) : mean_r[MAG_W-1:0];
    mmag     = mean_mag[48:16];
    mean16   = mean_r[MEAN_W-1] ? 32'(-mmag) : mmag[31:0];
    sig100   = 39'(sigma_r) * 39'(CONV_FACTOR);
    conv     = (sigma_r != '0) && (sig100 < 39'(mmag));
  end

  // Select divider and root operands
  always_comb begin
    div_go = cmd.div_step | cmd.div_var | cmd.div_hw;
    div_a  = {15'b0, (delta[MEAN_W-1] ? MAG_W'(-delta) : delta[MAG_W-1:0])};
    div_b  = {4'b0, n_r};
    if (cmd.div_var) begin
      div_a = sq_r;
      div_b = {4'b0, n_r - 1'b1};
    end else if (cmd.div_hw) begin
      div_a = {15'b0, hwp_r};
      div_b = rootn_r;
    end
    sqrt_go = cmd.sqrt_sig | cmd.sqrt_rn;
    sqrt_x  = cmd.sqrt_rn ? {7'b0, n_r, 32'b0} : {div_q[39:0], 24'b0};
  end

  omvs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  omvs_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_go), .radicand(sqrt_x),
    .done(sqrt_done), .root(sq_root)
  );

  // Partial-product multiplier control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrun_r  <= 1'b0;
      mdone_r <= 1'b0;
      mcnt_r  <= '0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.mul_go) begin
        mrun_r <= 1'b1;
        mcnt_r <= 2'd3;
      end else if (mrun_r) begin
        mcnt_r <= mcnt_r - 1'b1;
        if (mcnt_r == 2'd0) begin
          mrun_r  <= 1'b0;
          mdone_r <= 1'b1;
        end
      end
    end
  end

  // Accumulate one 13-bit slice of the second factor per clock
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mulb_r <= {3'b0, d2mag};
      prod_r <= '0;
    end else if (mrun_r) begin
      mulb_r <= mulb_r << 13;
      prod_r <= (prod_r << 13) + 101'(dmag_r * mulb_r[51:39]);
    end
  end

  // Run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mean_r <= '0;
      sq_r   <= '0;
      min_r  <= 32'sh7FFF_FFFF;
      max_r  <= 32'sh8000_0000;
      sat_r  <= 1'b0;
      tot_r  <= '0;
      conv_r <= '0;
    end else begin
      if (cmd.mean_upd) begin
        mean_r <= dneg_r ? mean_r - MEAN_W'(div_q) : mean_r + MEAN_W'(div_q);
      end
      if (cmd.acc) begin
        if (sum[64]) begin
          sq_r  <= '1;
          sat_r <= 1'b1;
        end else begin
          sq_r <= sum[63:0];
        end
        if (y_r < min_r) min_r <= y_r;
        if (y_r > max_r) max_r <= y_r;
        cnt_r <= n_r;
      end
      if (cmd.emit) begin
        tot_r <= tot_r + 1'b1;
        if (conv) conv_r <= conv_r + 1'b1;
        cnt_r  <= '0;
        mean_r <= '0;
        sq_r   <= '0;
        min_r  <= 32'sh7FFF_FFFF;
        max_r  <= 32'sh8000_0000;
        sat_r  <= 1'b0;
      end
    end
  end

  // Per-item and end-of-run working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r <= 32'(signed'(sample[SAMPLE_WIDTH-1:0]));
      n_r <= cnt_r + 1'b1;
    end
    if (cmd.div_step) begin
      dmag_r <= div_a[MAG_W-1:0];
      dneg_r <= delta[MEAN_W-1];
    end
    if (cmd.sig_zero) sigma_r <= '0;
    if (cmd.sig_sat)  sigma_r <= '1;
    if (cmd.sig_take) sigma_r <= sq_root;
    if (cmd.rn_take)  rootn_r <= sq_root[DIV_DW-1:0];
    if (cmd.hw_mul)   hwp_r <= 49'(sigma_r) * 49'(Z95_Q16);
  end

  // Result word, one strobe cycle
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_run_mean       <= mean16;
      out_run_stddev     <= sigma_r;
      out_run_minimum    <= min_r;
      out_run_maximum    <= max_r;
      out_half_width     <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
      out_converged      <= conv;
      out_runs_total     <= tot_r + 1'b1;
      out_runs_converged <= conv ? conv_r + 1'b1 : conv_r;
      out_m2_saturated   <= sat_r;
    end
  end

  always_comb begin
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.mul_done  = mdone_r;
    sts.run_end   = n_r >= limit;
    sts.multi     = n_r > CNT_W'(1);
    sts.var_big   = div_q[63:40] != '0;
  end
endmodule

// File: sv/omvs_ctrl.sv
module omvs_ctrl import omvs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (start) state_nxt = ST_STEP_GO;
      ST_STEP_GO:   state_nxt = ST_STEP_WAIT;
      ST_STEP_WAIT: if (sts.div_done) state_nxt = ST_MEAN;
      ST_MEAN:      state_nxt = ST_MUL_GO;
      ST_MUL_GO:    state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (sts.mul_done) state_nxt = ST_ACC;
      ST_ACC:       state_nxt = sts.run_end ? ST_VAR_GO : ST_IDLE;
      ST_VAR_GO:    state_nxt = sts.multi ? ST_VAR_WAIT : ST_RN_GO;
      ST_VAR_WAIT:  if (sts.div_done) state_nxt = ST_SIG_GO;
      ST_SIG_GO:    state_nxt = sts.var_big ? ST_RN_GO : ST_SIG_WAIT;
      ST_SIG_WAIT:  if (sts.sqrt_done) state_nxt = ST_RN_GO;
      ST_RN_GO:     state_nxt = ST_RN_WAIT;
      ST_RN_WAIT:   if (sts.sqrt_done) state_nxt = ST_HW_MUL;
      ST_HW_MUL:    state_nxt = ST_HW_GO;
      ST_HW_GO:     state_nxt = ST_HW_WAIT;
      ST_HW_WAIT:   if (sts.div_done) state_nxt = ST_EMIT;
      ST_EMIT:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd  = '0;
    busy = state_r != ST_IDLE;
    case (state_r)
      ST_IDLE:     cmd.load = start;
      ST_STEP_GO:  cmd.div_step = 1'b1;
      ST_MEAN:     cmd.mean_upd = 1'b1;
      ST_MUL_GO:   cmd.mul_go = 1'b1;
      ST_ACC:      cmd.acc = 1'b1;
      ST_VAR_GO: begin
        cmd.div_var  = sts.multi;
        cmd.sig_zero = !sts.multi;
      end
      ST_SIG_GO: begin
        cmd.sig_sat  = sts.var_big;
        cmd.sqrt_sig = !sts.var_big;
      end
      ST_SIG_WAIT: cmd.sig_take = sts.sqrt_done;
      ST_RN_GO:    cmd.sqrt_rn = 1'b1;
      ST_RN_WAIT:  cmd.rn_take = sts.sqrt_done;
      ST_HW_MUL:   cmd.hw_mul = 1'b1;
      ST_HW_GO:    cmd.div_hw = 1'b1;
      ST_EMIT:     cmd.emit = 1'b1;
      default:     cmd = '0;
    endcase
  end
endmodule

// File: sv/online_mean_variance_stats_core.sv
// Per sample: the next start is accepted only once busy falls, set by the shared
//   two-bit-per-cycle divider (delta/n) and the sliced multiplier.
// End of run adds the variance divide, two square roots and the half-width divide; a
//   one-sample run skips the variance divide and the first root, and a saturated variance
//   skips the first root; the result strobe follows the half-width divide.
// Results are not back-pressured. Synchronous active-low reset clears the run
//   accumulators and run counters, presets min/max and sets iteration_count to 10000.
`include "online_mean_variance_stats_core_defines.svh"
module online_mean_variance_stats_core import omvs_pkg::*; #(
  parameter int unsigned MAX_RUN_LENGTH = 16777216,
  parameter int unsigned SAMPLE_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_sample_value,
  output logic        out_valid,
  output logic [31:0] out_run_mean,
  output logic [31:0] out_run_stddev,
  output logic [31:0] out_run_minimum,
  output logic [31:0] out_run_maximum,
  output logic [31:0] out_half_width,
  output logic        out_converged,
  output logic [31:0] out_runs_total,
  output logic [31:0] out_runs_converged,
  output logic        out_m2_saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [CNT_W-1:0] iter_r, limit;
  cmd_t             cmd;
  sts_t             sts;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= ITER_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      iter_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {7'b0, iter_r};

  // Clamp run length
  always_comb begin
    if (iter_r == '0)                         limit = CNT_W'(1);
    else if (iter_r > CNT_W'(MAX_RUN_LENGTH)) limit = CNT_W'(MAX_RUN_LENGTH);
    else                                      limit = iter_r;
  end

  omvs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  omvs_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .limit(limit),
    .sample(in_sample_value), .out_valid(out_valid), .out_run_mean(out_run_mean),
    .out_run_stddev(out_run_stddev), .out_run_minimum(out_run_minimum),
    .out_run_maximum(out_run_maximum), .out_half_width(out_half_width),
    .out_converged(out_converged), .out_runs_total(out_runs_total),
    .out_runs_converged(out_runs_converged), .out_m2_saturated(out_m2_saturated)
  );

  `OMVS_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe too long")
  `OMVS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `OMVS_ASSERT_IMP(a_conv_sigma, out_valid && out_converged, out_run_stddev != '0, "zero sigma")
endmodule
